// ===== sv/assert_macros.svh =====
// Assertion macros shared by the line table RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the asynchronous reset is active.
`define RLLT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define RLLT_NEVER(label, clk, rst_n, cond, msg) \
	`RLLT_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

// ===== sv/rllt_pkg.sv =====
// Shared types, codes and default sizes of the run-length line table.
// Depends on nothing; used by the controller, the datapath and the top level.
package rllt_pkg;

	localparam int MAX_RUNS_DEF   = 256;
	localparam int MAX_BYTES_DEF  = 4096;
	localparam int LINE_WIDTH_DEF = 16;

	// Fixed widths of the request and response fields.
	localparam int LN_W  = 16;
	localparam int OFF_W = 12;
	localparam int ST_W  = 2;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_MISS = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic             opcode;
		logic [LN_W-1:0]  line_number;
		logic [OFF_W-1:0] byte_offset;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [LN_W-1:0]  found_line;
		logic [OFF_W-1:0] assigned_offset;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic walk_step;
		logic do_append;
		logic do_lookup;
	} ctl_cmd_t;

	typedef struct packed {
		logic hit;
		logic miss;
	} dp_status_t;

endpackage

// ===== sv/run_length_line_table.sv =====
// Top level of the run-length line table.
// Depends on rllt_pkg, rllt_ctrl, rllt_dp and assert_macros.svh.

// The table maps byte positions of a code stream to source lines as a list of
// runs. An append request assigns the next byte position to its line, growing
// the last run when the line repeats and opening a new run otherwise, and
// answers the position it gave; it is refused with a full status once
// MAX_BYTES bytes are used, or once MAX_RUNS runs are used when it needs a new
// run. A lookup request answers the line of the run that covers its offset, or
// a not-covered status. Requests are handled one at a time. An append is
// captured, then its result is loaded into the output register once that
// register is free. A lookup walks the runs through one read port of the
// run memories, one run per cycle, until it reaches the covering run or
// passes the last one, then loads its result the same way; on an empty table
// it misses without reading a run. The next request is accepted in the cycle
// after the response is loaded into the output register, even while that
// response still waits to be taken. The run memories need no clearing after
// reset: a slot past the last run may be read, but its value is never used.
module run_length_line_table #(
	parameter int MAX_RUNS   = rllt_pkg::MAX_RUNS_DEF,
	parameter int MAX_BYTES  = rllt_pkg::MAX_BYTES_DEF,
	parameter int LINE_WIDTH = rllt_pkg::LINE_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  rllt_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output rllt_pkg::rsp_t rsp
);
	import rllt_pkg::*;

	`include "assert_macros.svh"

	ctl_cmd_t   cmd;
	dp_status_t status;

	// The controller sequences each request; the datapath owns all storage.
	rllt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_opcode (req.opcode),
		.req_stall  (req_stall),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.cmd        (cmd)
	);

	rllt_dp #(
		.MAX_RUNS   (MAX_RUNS),
		.MAX_BYTES  (MAX_BYTES),
		.LINE_WIDTH (LINE_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.status (status),
		.rsp    (rsp)
	);

	// A result is only loaded when the output register is free or being drained.
	`RLLT_ASSERT(a_no_overwrite, clk, arst_n, (cmd.do_append || cmd.do_lookup) |-> (!rsp_valid || !rsp_stall), "response overwritten while held")
	// After a request is taken, no second one is taken in the next cycle.
	`RLLT_ASSERT(a_one_at_a_time, clk, arst_n, (req_valid && !req_stall) |=> req_stall, "request accepted while busy")
	// A finished request produces exactly one kind of result.
	`RLLT_NEVER(a_single_finish, clk, arst_n, cmd.do_append && cmd.do_lookup, "append and lookup finished together")

endmodule

// ===== sv/rllt_ctrl.sv =====
// Controller state machine of the run-length line table.
// Depends on rllt_pkg; drives the datapath through ctl_cmd_t commands.
module rllt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_opcode,
	output logic                 req_stall,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  rllt_pkg::dp_status_t status,
	output rllt_pkg::ctl_cmd_t   cmd
);
	import rllt_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_APPEND = 2'd1;
	localparam logic [1:0] S_WALK   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       rsp_valid_q;
	logic       slot_free;
	logic       finish;

	// The response slot can take a new result when empty or being drained now.
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign finish    = cmd.do_append || cmd.do_lookup;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = (req_opcode == OP_LOOKUP) ? S_WALK : S_APPEND;
				end
			end
			S_APPEND: begin
				if (slot_free) begin
					cmd.do_append = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_WALK: begin
				if (status.hit || status.miss) begin
					if (slot_free) begin
						cmd.do_lookup = 1'b1;
						state_d       = S_IDLE;
					end
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/rllt_dp.sv =====
// Datapath of the run-length line table: run memories, counters, walk and result.
// Depends on rllt_pkg; steered by rllt_ctrl through ctl_cmd_t commands.
module rllt_dp #(
	parameter int MAX_RUNS   = rllt_pkg::MAX_RUNS_DEF,
	parameter int MAX_BYTES  = rllt_pkg::MAX_BYTES_DEF,
	parameter int LINE_WIDTH = rllt_pkg::LINE_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rllt_pkg::req_t       req,
	input  rllt_pkg::ctl_cmd_t   cmd,
	output rllt_pkg::dp_status_t status,
	output rllt_pkg::rsp_t       rsp
);
	import rllt_pkg::*;

	localparam int IW  = $clog2(MAX_RUNS);
	localparam int RCW = $clog2(MAX_RUNS + 1);
	localparam int BCW = $clog2(MAX_BYTES + 1);
	localparam int RW  = (BCW > OFF_W) ? BCW : OFF_W;

	logic [LINE_WIDTH-1:0] line_mem [MAX_RUNS];
	logic [BCW-1:0]        len_mem  [MAX_RUNS];

	req_t                  req_q;
	rsp_t                  rsp_q;
	logic [RCW-1:0]        run_total_q;
	logic [BCW-1:0]        byte_total_q;
	logic [LINE_WIDTH-1:0] last_line_q;
	logic [BCW-1:0]        last_len_q;
	logic [IW-1:0]         rd_addr_q;
	logic [RCW-1:0]        cmp_idx_q;
	logic [RW-1:0]         rem_q;
	logic                  pend_q;
	logic [LINE_WIDTH-1:0] rd_line_q;
	logic [BCW-1:0]        rd_len_q;

	logic [31:0]           line_ext;
	logic [LINE_WIDTH-1:0] line_st;
	logic [31:0]           pos_ext;
	logic [31:0]           found_ext;
	logic [RW-1:0]         len_ext;
	logic                  merge;
	logic                  full;
	logic [IW-1:0]         last_idx;
	logic [IW-1:0]         wr_addr;

	assign line_ext  = 32'(req_q.line_number);
	assign line_st   = line_ext[LINE_WIDTH-1:0];
	assign pos_ext   = 32'(byte_total_q);
	assign found_ext = 32'(rd_line_q);
	assign len_ext   = RW'(rd_len_q);
	assign last_idx  = IW'(run_total_q - RCW'(1));

	assign merge   = (run_total_q != '0) && (last_line_q == line_st);
	assign full    = (byte_total_q >= BCW'(MAX_BYTES)) ||
	                 (!merge && (run_total_q >= RCW'(MAX_RUNS)));
	assign wr_addr = merge ? last_idx : run_total_q[IW-1:0];

	// Compared runs have all been written; the slot past the last run is never a hit.
	assign status.miss = (cmp_idx_q == run_total_q);
	assign status.hit  = pend_q && !status.miss && (rem_q < len_ext);
	assign rsp         = rsp_q;

	always_ff @(posedge clk) begin
		if (cmd.do_append && !full) begin
			len_mem[wr_addr] <= merge ? (last_len_q + BCW'(1)) : BCW'(1);
			if (!merge) begin
				line_mem[wr_addr] <= line_st;
			end
		end
		if (cmd.walk_step) begin
			rd_line_q <= line_mem[rd_addr_q];
			rd_len_q  <= len_mem[rd_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_total_q  <= '0;
			byte_total_q <= '0;
			pend_q       <= 1'b0;
		end else begin
			if (cmd.capture) begin
				pend_q <= 1'b0;
			end else if (cmd.walk_step) begin
				pend_q <= 1'b1;
			end
			if (cmd.do_append && !full) begin
				byte_total_q <= byte_total_q + BCW'(1);
				if (!merge) begin
					run_total_q <= run_total_q + RCW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q     <= req;
			rd_addr_q <= '0;
			cmp_idx_q <= '0;
			rem_q     <= RW'(req.byte_offset);
		end
		if (cmd.walk_step) begin
			rd_addr_q <= rd_addr_q + IW'(1);
			if (pend_q) begin
				rem_q     <= rem_q - len_ext;
				cmp_idx_q <= cmp_idx_q + RCW'(1);
			end
		end
		if (cmd.do_append && !full) begin
			if (merge) begin
				last_len_q <= last_len_q + BCW'(1);
			end else begin
				last_line_q <= line_st;
				last_len_q  <= BCW'(1);
			end
		end
		if (cmd.do_append) begin
			if (full) begin
				rsp_q <= '{status: ST_FULL, found_line: '0, assigned_offset: '0};
			end else begin
				rsp_q <= '{status: ST_OK, found_line: '0,
				           assigned_offset: pos_ext[OFF_W-1:0]};
			end
		end else if (cmd.do_lookup) begin
			if (status.hit) begin
				rsp_q <= '{status: ST_OK, found_line: found_ext[LN_W-1:0],
				           assigned_offset: '0};
			end else begin
				rsp_q <= '{status: ST_MISS, found_line: '0, assigned_offset: '0};
			end
		end
	end

endmodule

// ===== dv/run_length_line_table_test.sv =====
// Self-checking testbench for the run-length line table (run_length_line_table).
// Depends on rllt_pkg for the request and response types and codes, and on the block itself.
module run_length_line_table_test;

	import rllt_pkg::*;

	// The block is built with its default sizes, so the testbench uses the same ones.
	localparam int TABLE_RUNS  = MAX_RUNS_DEF;
	localparam int TABLE_BYTES = MAX_BYTES_DEF;
	// Even with every lookup walking every run, the receiver stalling most cycles and
	// the long hold-off, about fifteen hundred requests stay far below this bound.
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int HOLD_CYCLES = 600;
	localparam int CHUNK       = 50;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	run_length_line_table DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Expected contents of the table. The lengths are kept as plain counts.
	logic [LN_W-1:0] run_line_mem [TABLE_RUNS];
	int unsigned     run_len_mem  [TABLE_RUNS];
	int unsigned     run_count  = 0;
	int unsigned     byte_count = 0;

	req_t requests_to_send [$];
	rsp_t answers_due [$];
	int   requests_queued = 0;
	int   answers_checked = 0;
	int   mismatches      = 0;
	int   cycle_count     = 0;
	logic req_done        = 1'b0;

	// Idle rates in percent; the stimulus sets them phase by phase.
	int send_idle = 0;
	int recv_idle = 0;

	// The stimulus orders a long receiver hold-off by bumping hold_orders; the hold-off
	// process below serves each order once and counts the held cycles itself.
	int hold_orders = 0;
	int hold_served = 0;
	int hold_left   = 0;

	// What the generator believes the table looks like while it fills a chunk. It is
	// resynchronized with the expected table at the start of every chunk.
	logic [LN_W-1:0] plan_line  = '0;
	int unsigned     plan_bytes = 0;

	// Applies one request to the expected table and returns the response it must give.
	function automatic rsp_t table_answer(req_t r);
		rsp_t        ans;
		int unsigned rem;
		logic        hit;
		ans = '0;
		if (r.opcode == OP_APPEND) begin
			if (byte_count >= TABLE_BYTES) begin
				// Byte count exhausted: nothing changes.
				ans.status = ST_FULL;
			end else if (run_count > 0 && run_line_mem[run_count - 1] == r.line_number) begin
				// Same line as the last run, so that run just grows.
				run_len_mem[run_count - 1]++;
				ans.status          = ST_OK;
				ans.assigned_offset = OFF_W'(byte_count);
				byte_count++;
			end else if (run_count >= TABLE_RUNS) begin
				// A new run is needed but the run table is exhausted.
				ans.status = ST_FULL;
			end else begin
				run_line_mem[run_count] = r.line_number;
				run_len_mem[run_count]  = 1;
				run_count++;
				ans.status          = ST_OK;
				ans.assigned_offset = OFF_W'(byte_count);
				byte_count++;
			end
		end else begin
			// Walk the runs in order, taking each length off the offset, as the block does.
			rem = 32'(r.byte_offset);
			hit = 1'b0;
			for (int i = 0; i < TABLE_RUNS; i++) begin
				if (!hit && i < run_count) begin
					if (rem < run_len_mem[i]) begin
						hit            = 1'b1;
						ans.found_line = run_line_mem[i];
					end else begin
						rem -= run_len_mem[i];
					end
				end
			end
			ans.status = hit ? ST_OK : ST_MISS;
		end
		return ans;
	endfunction

	task automatic note_mismatch(string what, rsp_t want, rsp_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("ERROR %s at cycle %0d: expected status %0d line %h offset %h, got status %0d line %h offset %h",
				what, cycle_count, want.status, want.found_line, want.assigned_offset,
				got.status, got.found_line, got.assigned_offset);
		end
	endtask

	task automatic push_request(logic op, logic [LN_W-1:0] line, logic [OFF_W-1:0] off);
		req_t r;
		r.opcode      = op;
		r.line_number = line;
		r.byte_offset = off;
		requests_to_send.push_back(r);
		requests_queued++;
	endtask

	// Holds the sender back until every response asked for so far has come.
	task automatic wait_drained();
		while (answers_checked < requests_queued)
			@(posedge clk);
	endtask

	// One chunk of random requests. Appends either repeat the line of the last run, which
	// grows it, or bring a new line; lookups mostly aim at covered offsets and a little past
	// the end, with some spread over the whole offset range. Unused fields carry noise.
	task automatic random_chunk(int count, int append_pct, int new_pct);
		logic [LN_W-1:0]  line;
		logic [OFF_W-1:0] off;
		int unsigned      top;
		plan_line  = (run_count > 0) ? run_line_mem[run_count - 1] : '0;
		plan_bytes = byte_count;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < append_pct) begin
				if (plan_bytes == 0 || $urandom_range(99) < new_pct) begin
					case ($urandom_range(15))
						0: begin
							line = '0;
						end
						1: begin
							line = '1;
						end
						default: begin
							line = LN_W'($urandom);
						end
					endcase
					// Once the run table is full a new line is refused, so the last run keeps
					// its line.
					if (run_count < TABLE_RUNS)
						plan_line = line;
				end else begin
					line = plan_line;
				end
				push_request(OP_APPEND, line, OFF_W'($urandom));
				if (plan_bytes < TABLE_BYTES)
					plan_bytes++;
			end else begin
				if ($urandom_range(7) == 0) begin
					off = OFF_W'($urandom);
				end else begin
					top = plan_bytes + 2;
					if (top > TABLE_BYTES - 1)
						top = TABLE_BYTES - 1;
					off = OFF_W'($urandom_range(top, 0));
				end
				push_request(OP_LOOKUP, LN_W'($urandom), off);
			end
		end
		wait_drained();
	endtask

	// Request driver. A new request goes out on the falling edge only once the previous one
	// was taken, so a request that is stalled stays on the bus unchanged.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_done) begin
			if (requests_to_send.size() > 0 && $urandom_range(99) >= send_idle) begin
				req_valid <= 1'b1;
				req       <= requests_to_send.pop_front();
			end else begin
				req_valid <= 1'b0;
			end
		end
		rsp_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_orders) begin
			hold_served <= hold_orders;
			hold_left   <= HOLD_CYCLES;
		end
	end

	// Monitor. Each response taken is checked against the oldest expected one, and each
	// request taken is run through the expected table to queue its response.
	always @(posedge clk) begin : watch
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				answers_checked++;
				if (answers_due.size() == 0) begin
					note_mismatch("response with none due", '0, rsp);
				end else begin
					want = answers_due.pop_front();
					if (rsp.status !== want.status || rsp.found_line !== want.found_line ||
						rsp.assigned_offset !== want.assigned_offset)
						note_mismatch("wrong response", want, rsp);
				end
			end
			if (req_valid && !req_stall)
				answers_due.push_back(table_answer(req));
			req_done <= req_valid && !req_stall;
		end else begin
			req_done <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("run_length_line_table: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// First phase: the sender idles a little and the receiver stalls most of the time.
		send_idle = 12;
		recv_idle = 79;

		// Directed requests. Lookups on the empty table miss. Then come repeated and new
		// lines at the extreme values, a line that equals an earlier run but not the last
		// one, lookups at the first and last covered byte and just past the end, and
		// noise in the fields that each operation ignores.
		push_request(OP_LOOKUP, '0, '0);
		push_request(OP_LOOKUP, '1, '1);
		push_request(OP_APPEND, '0, '0);
		push_request(OP_APPEND, '0, '1);
		push_request(OP_APPEND, '1, '0);
		push_request(OP_APPEND, '1, 12'h555);
		push_request(OP_APPEND, '0, 12'hAAA);
		push_request(OP_APPEND, 16'h5555, '1);
		push_request(OP_APPEND, 16'hAAAA, '0);
		push_request(OP_LOOKUP, 16'hAAAA, 12'd0);
		push_request(OP_LOOKUP, 16'h5555, 12'd1);
		push_request(OP_LOOKUP, '1, 12'd2);
		push_request(OP_LOOKUP, '0, 12'd4);
		push_request(OP_LOOKUP, '0, 12'd6);
		push_request(OP_LOOKUP, '0, 12'd7);
		push_request(OP_LOOKUP, '1, '1);
		push_request(OP_LOOKUP, '0, 12'hAAA);
		push_request(OP_LOOKUP, '0, 12'h555);
		push_request(OP_APPEND, 16'h0001, '0);
		push_request(OP_APPEND, 16'h8000, '0);
		push_request(OP_LOOKUP, '0, 12'd8);
		push_request(OP_LOOKUP, '0, 12'd9);
		wait_drained();

		for (int c = 0; c < 10; c++)
			random_chunk(CHUNK, 55, 35);

		// Second phase: the sender idles most of the time and the receiver rarely stalls.
		send_idle = 79;
		recv_idle = 12;
		for (int c = 0; c < 10; c++)
			random_chunk(CHUNK, 55, 35);

		// Third phase: no idling at all. It starts with a long receiver hold-off while the
		// sender keeps offering requests, so the block fills and stalls its input. The chunks
		// lean toward new lines so the run table runs out of room.
		send_idle = 0;
		recv_idle = 0;
		hold_orders++;
		for (int c = 0; c < 6; c++)
			random_chunk(CHUNK, 70, 60);

		// With the run table full, try a few more appends, both repeated and new lines; the
		// new lines must be refused.
		plan_line = (run_count > 0) ? run_line_mem[run_count - 1] : '0;
		for (int n = 0; n < 3; n++) begin
			push_request(OP_APPEND, plan_line, OFF_W'($urandom));
			push_request(OP_APPEND, LN_W'($urandom), OFF_W'($urandom));
		end
		push_request(OP_LOOKUP, LN_W'($urandom), '1);
		push_request(OP_LOOKUP, LN_W'($urandom), '0);
		wait_drained();

		for (int c = 0; c < 2; c++)
			random_chunk(CHUNK, 20, 50);

		// Let a full lookup walk pass so that a stray response would still be seen.
		wait_drained();
		repeat (TABLE_RUNS + 16) @(posedge clk);
		if (mismatches == 0 && answers_due.size() == 0) begin
			$display("run_length_line_table: match");
		end else begin
			$display("run_length_line_table: mismatch");
		end
		$finish;
	end

endmodule
